FILE: rtl/core/ghs_pkg.sv
// Shared widths, register indexes and handoff types of the histogram smoother.
package ghs_pkg;

   localparam int HW_W      = 3;   // half width register
   localparam int BIN_W     = 32;  // bin weight, Q16.16
   localparam int TAP_W     = 24;  // tap, Q8.16
   localparam int OUT_W     = 40;  // smoothed value, Q24.16
   localparam int FRAC_W    = 16;  // fraction bits dropped by the rounding step
   localparam int TAP_COUNT = 7;   // center tap plus offsets one to six
   localparam int PAIR_W    = BIN_W + 1;
   localparam int PROD_W    = PAIR_W + TAP_W;
   localparam int CSR_IDX_W = 3;

   // Q8.16 unity, used as the center tap in pass-through mode
   localparam logic [TAP_W-1:0] TAP_UNITY = TAP_W'(1) << FRAC_W;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_CENTER = CSR_IDX_W'(1);

   // one filter step handed from the window sequencer to the datapath
   typedef struct packed {
      logic valid;
      logic final_out;
   } ghs_step_type;

endpackage

FILE: rtl/core/gaussian_histogram_smoother.sv
// Top level of the Gaussian histogram smoother: registers, window and datapath.
// Pipeline: a result word passes the window, pair, product, partial sum and
// output registers after its bin word is accepted; the flushed words of a
// final bin follow it, and any of them come later under backpressure.
// Throughput: one bin word per cycle without backpressure; a final bin holds
// the window while its h trailing results flush (h = effective half width).
// Reset: synchronous, active high; clears registers, bin history and all valids.
module gaussian_histogram_smoother
   import ghs_pkg::*;
#(
   parameter int MAX_HALF = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   // bin words
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BIN_W-1:0]     req_tdata,   // [31:0] bin_weight
   input  logic                 req_tlast,   // final_bin
   // smoothed words
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [OUT_W-1:0]     rsp_tdata,   // [39:0] smoothed_value
   output logic                 rsp_tlast,   // final_out
   // configuration writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TAP_W-1:0]     csr_wdata
);

   logic [HW_W-1:0]                    half_width_ff;
   logic [TAP_COUNT-1:0][TAP_W-1:0]    tap_ff;
   logic [HW_W-1:0]                    h_eff;

   ghs_step_type                       step;
   logic                               step_ready;
   logic [2*MAX_HALF:0][BIN_W-1:0]     win;
   logic [HW_W-1:0]                    win_h;

   // Register file: index 0 is the half width, 1..7 the taps from center out.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= '0;
         tap_ff        <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_HALF_WIDTH) begin
            half_width_ff <= csr_wdata[HW_W-1:0];
         end else begin
            tap_ff[csr_index - CSR_TAP_CENTER] <= csr_wdata;
         end
      end
   end

   // Half widths beyond the built window depth act as the largest one.
   always_comb begin
      if (int'(half_width_ff) > MAX_HALF) begin
         h_eff = HW_W'(MAX_HALF);
      end else begin
         h_eff = half_width_ff;
      end
   end

   // Delay line and flush sequencer: a final bin is followed by h zero bins,
   // and steps whose center falls before the histogram start are dropped.
   ghs_window #(
      .MAX_HALF (MAX_HALF)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_weight (req_tdata),
      .req_final  (req_tlast),
      .h_eff      (h_eff),
      .step_ready (step_ready),
      .step       (step),
      .win        (win),
      .win_h      (win_h)
   );

   // Symmetric FIR: pre-add mirrored bins, one multiplier per offset,
   // two-level sum, round half up to Q24.16 and saturate. Half width zero
   // runs the bin through the center lane at unity gain.
   ghs_datapath #(
      .MAX_HALF (MAX_HALF)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .step_ready (step_ready),
      .win        (win),
      .win_h      (win_h),
      .taps       (tap_ff),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_final  (rsp_tlast)
   );

endmodule

FILE: rtl/core/ghs_window.sv
// Bin history, sample window and flush sequencer of the histogram smoother.
module ghs_window
   import ghs_pkg::*;
#(
   parameter int MAX_HALF = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [BIN_W-1:0]                       req_weight,
   input  logic                                   req_final,
   input  logic [HW_W-1:0]                        h_eff,
   input  logic                                   step_ready,
   output ghs_step_type                           step,
   output logic [2*MAX_HALF:0][BIN_W-1:0]         win,
   output logic [HW_W-1:0]                        win_h
);

   localparam int DEPTH  = 2 * MAX_HALF;
   localparam int WIN    = DEPTH + 1;
   localparam int SEEN_W = $clog2(MAX_HALF + 1);

   logic [BIN_W-1:0]  hist_ff [DEPTH];
   logic [BIN_W-1:0]  hist_in [DEPTH];
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [BIN_W-1:0]  win_ff [WIN];
   logic [BIN_W-1:0]  win_in [WIN];
   logic              vld_ff, vld_in;
   logic              fin_ff, fin_in;
   logic [HW_W-1:0]   h_ff, h_in;
   logic [HW_W-1:0]   d_ff, d_in;
   logic [HW_W-1:0]   skip_ff, skip_in;

   logic              emit, last, fire, accept;
   logic [HW_W-1:0]   seen_lim;

   // a step yields a word only when its center bin lies inside the histogram
   assign emit      = (d_ff >= skip_ff);
   assign last      = !fin_ff || (d_ff == h_ff);
   assign fire      = vld_ff && (step_ready || !emit);
   assign req_ready = !vld_ff || (fire && last);
   assign accept    = req_valid && req_ready;

   assign step.valid     = vld_ff && emit;
   assign step.final_out = fin_ff && last;
   assign win_h          = h_ff;

   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         win[j] = win_ff[j];
      end
   end

   always_comb begin
      if (int'(seen_ff) < int'(h_eff)) begin
         seen_lim = HW_W'(seen_ff);
      end else begin
         seen_lim = h_eff;
      end
   end

   always_comb begin
      hist_in = hist_ff;
      seen_in = seen_ff;
      win_in  = win_ff;
      vld_in  = vld_ff;
      fin_in  = fin_ff;
      h_in    = h_ff;
      d_in    = d_ff;
      skip_in = skip_ff;

      // flush: shift a zero bin into the window
      if (fire && !last) begin
         win_in[0] = '0;
         for (int j = 1; j < WIN; j++) begin
            win_in[j] = win_ff[j-1];
         end
         d_in = d_ff + HW_W'(1);
      end
      if (fire && last) begin
         vld_in = 1'b0;
      end

      if (accept) begin
         vld_in    = 1'b1;
         win_in[0] = req_weight;
         for (int j = 1; j < WIN; j++) begin
            win_in[j] = hist_ff[j-1];
         end
         h_in   = h_eff;
         d_in   = '0;
         fin_in = req_final;
         if (req_final) begin
            skip_in = h_eff - seen_lim;
         end else if (seen_lim >= h_eff) begin
            skip_in = '0;
         end else begin
            skip_in = HW_W'(1);
         end

         if (req_final) begin
            for (int j = 0; j < DEPTH; j++) begin
               hist_in[j] = '0;
            end
            seen_in = '0;
         end else begin
            hist_in[0] = req_weight;
            for (int j = 1; j < DEPTH; j++) begin
               hist_in[j] = hist_ff[j-1];
            end
            if (int'(seen_ff) < MAX_HALF) begin
               seen_in = seen_ff + SEEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         seen_ff <= '0;
         for (int j = 0; j < DEPTH; j++) begin
            hist_ff[j] <= '0;
         end
      end else begin
         vld_ff  <= vld_in;
         seen_ff <= seen_in;
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      fin_ff  <= fin_in;
      h_ff    <= h_in;
      d_ff    <= d_in;
      skip_ff <= skip_in;
   end

endmodule

FILE: rtl/core/ghs_datapath.sv
// Tap select, multiply, sum, rounding and saturation pipeline of the smoother.
module ghs_datapath
   import ghs_pkg::*;
#(
   parameter int MAX_HALF = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ghs_step_type                        step,
   output logic                                step_ready,
   input  logic [2*MAX_HALF:0][BIN_W-1:0]      win,
   input  logic [HW_W-1:0]                     win_h,
   input  logic [TAP_COUNT-1:0][TAP_W-1:0]     taps,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [OUT_W-1:0]                    rsp_value,
   output logic                                rsp_final
);

   localparam int WIN   = 2 * MAX_HALF + 1;
   localparam int LANES = MAX_HALF + 1;
   localparam int SUM_W = PROD_W + $clog2(LANES) + 1;
   localparam int SHR_W = SUM_W - FRAC_W;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_W - 1);

   // stage 2: symmetric pairs
   logic              s2_vld_ff, s2_fin_ff, s2_pass_ff;
   logic              s2_pass_in;
   logic [PAIR_W-1:0] s2_pair_ff [LANES];
   logic [PAIR_W-1:0] s2_pair_in [LANES];
   // stage 3: products
   logic              s3_vld_ff, s3_fin_ff;
   logic [PROD_W-1:0] s3_prod_ff [LANES];
   logic [PROD_W-1:0] s3_prod_in [LANES];
   logic [TAP_W-1:0]  tap_lane [LANES];
   // stage 4: two partial sums
   logic              s4_vld_ff, s4_fin_ff;
   logic [SUM_W-1:0]  s4_even_ff, s4_odd_ff, s4_even_in, s4_odd_in;
   // stage 5: result word
   logic              o_vld_ff, o_fin_ff;
   logic [OUT_W-1:0]  o_value_ff, o_value_in;
   logic [SUM_W-1:0]  total;
   logic [SHR_W-1:0]  shifted;

   logic out_rdy, s4_rdy, s3_rdy, s2_rdy;

   assign out_rdy    = !o_vld_ff || rsp_ready;
   assign s4_rdy     = !s4_vld_ff || out_rdy;
   assign s3_rdy     = !s3_vld_ff || s4_rdy;
   assign s2_rdy     = !s2_vld_ff || s3_rdy;
   assign step_ready = s2_rdy;

   assign rsp_valid = o_vld_ff;
   assign rsp_value = o_value_ff;
   assign rsp_final = o_fin_ff;

   // center at win[h]; offset k pairs win[h-k] with win[h+k]
   always_comb begin
      logic [BIN_W-1:0] lo;
      logic [BIN_W-1:0] hi;
      for (int k = 0; k < LANES; k++) begin
         lo = '0;
         hi = '0;
         for (int j = 0; j < WIN; j++) begin
            if (j == int'(win_h) - k) lo = win[j];
            if (j == int'(win_h) + k) hi = win[j];
         end
         if (k == 0) begin
            s2_pair_in[k] = PAIR_W'(hi);
         end else if (k <= int'(win_h)) begin
            s2_pair_in[k] = PAIR_W'(lo) + PAIR_W'(hi);
         end else begin
            s2_pair_in[k] = '0;
         end
      end
   end

   assign s2_pass_in = (win_h == '0);

   // offsets past the last tap register weigh zero
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         tap_lane[k] = '0;
         for (int t = 0; t < TAP_COUNT; t++) begin
            if (t == k) tap_lane[k] = taps[t];
         end
      end
      if (s2_pass_ff) begin
         tap_lane[0] = TAP_UNITY;
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         s3_prod_in[k] = PROD_W'(s2_pair_ff[k]) * PROD_W'(tap_lane[k]);
      end
   end

   always_comb begin
      s4_even_in = '0;
      s4_odd_in  = '0;
      for (int k = 0; k < LANES; k++) begin
         if ((k % 2) == 0) begin
            s4_even_in = s4_even_in + SUM_W'(s3_prod_ff[k]);
         end else begin
            s4_odd_in = s4_odd_in + SUM_W'(s3_prod_ff[k]);
         end
      end
   end

   // round to Q24.16 and clamp
   assign total   = s4_even_ff + s4_odd_ff + ROUND_HALF;
   assign shifted = total[SUM_W-1:FRAC_W];

   always_comb begin
      if (|shifted[SHR_W-1:OUT_W]) begin
         o_value_in = '1;
      end else begin
         o_value_in = shifted[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         if (s2_rdy) s2_vld_ff <= step.valid;
         if (s3_rdy) s3_vld_ff <= s2_vld_ff;
         if (s4_rdy) s4_vld_ff <= s3_vld_ff;
         if (out_rdy) o_vld_ff <= s4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_fin_ff  <= step.final_out;
         s2_pass_ff <= s2_pass_in;
         s2_pair_ff <= s2_pair_in;
      end
      if (s3_rdy) begin
         s3_fin_ff  <= s2_fin_ff;
         s3_prod_ff <= s3_prod_in;
      end
      if (s4_rdy) begin
         s4_fin_ff  <= s3_fin_ff;
         s4_even_ff <= s4_even_in;
         s4_odd_ff  <= s4_odd_in;
      end
      if (out_rdy) begin
         o_fin_ff   <= s4_fin_ff;
         o_value_ff <= o_value_in;
      end
   end

endmodule
